FILE: design/ilc_pkg.sv
// ----------------------------------------------------------------------------
// ilc_pkg
// Shared types and constants for the x86-64 instruction length classifier.
// ----------------------------------------------------------------------------
package ilc_pkg;

  localparam int unsigned WinBytes = 16;
  localparam int unsigned QDepth   = 2;

  localparam logic [7:0] OpcF3    = 8'hF3;
  localparam logic [7:0] Opc1E    = 8'h1E;
  localparam logic [7:0] OpcFA    = 8'hFA;
  localparam logic [7:0] Opc0F    = 8'h0F;
  localparam logic [7:0] Opc38    = 8'h38;
  localparam logic [7:0] Opc3A    = 8'h3A;
  localparam logic [7:0] OpcCall  = 8'hE8;
  localparam logic [7:0] OpcJmp   = 8'hE9;
  localparam logic [7:0] OpcJmpS  = 8'hEB;
  localparam logic [7:0] OpcEvex  = 8'h62;
  localparam logic [7:0] OpcVex3  = 8'hC4;
  localparam logic [7:0] OpcVex2  = 8'hC5;
  localparam logic [7:0] OpcRet   = 8'hC3;
  localparam logic [7:0] OpcRetI  = 8'hC2;
  localparam logic [7:0] OpcJmpF  = 8'hEA;

  typedef enum logic [2:0] {
    ClsOther = 3'd0,
    ClsCall  = 3'd1,
    ClsJmp   = 3'd2,
    ClsJcc   = 3'd3,
    ClsRet   = 3'd4,
    ClsRip   = 3'd5,
    ClsCet   = 3'd6
  } insn_class_e;

  typedef struct packed {
    logic [63:0] code_high;
    logic [63:0] code_low;
  } insn_req_t;

  typedef struct packed {
    logic [4:0]         insn_length;
    logic [2:0]         insn_class;
    logic [4:0]         rewrite_size;
    logic [4:0]         rel_field_offset;
    logic signed [31:0] rip_displacement;
  } insn_res_t;

  // window with its prefix scan done
  typedef struct packed {
    logic [127:0] win;
    logic [4:0]   pfx_len;
    logic [7:0]   rex;
    logic         f3_seen;
  } ilc_fe_t;

  function automatic logic [7:0] byte_at(logic [127:0] w, logic [5:0] pos);
    logic [7:0] r;
    r = 8'h00;
    if (pos < 6'(WinBytes)) r = w[{pos[3:0], 3'b000} +: 8];
    return r;
  endfunction

endpackage

FILE: design/ilc_front.sv
// ----------------------------------------------------------------------------
// ilc_front
// Two-stage prefix scanner: eight prefix steps per stage, then F3 detection.
// ----------------------------------------------------------------------------
module ilc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ilc_pkg::insn_req_t req_i,
  output logic              push_o,
  output ilc_pkg::ilc_fe_t  push_data_o,
  input  logic              full_i
);
  import ilc_pkg::*;

  typedef struct packed {
    logic [5:0] p;
    logic [7:0] rex;
    logic       stop;
  } scan_t;

  function automatic scan_t scan8(logic [127:0] w, scan_t s_in);
    scan_t s;
    logic [7:0] c;
    s = s_in;
    for (int i = 0; i < 8; i++) begin
      if (!s.stop && s.p < 6'(WinBytes)) begin
        c = byte_at(w, s.p);
        if (c inside {[8'h40:8'h4F]}) begin
          s.rex = c;
          s.p   = s.p + 6'd1;
        end else if (c inside {8'h66, 8'h67, 8'hF0, 8'hF2, 8'hF3, 8'h26, 8'h2E,
                               8'h36, 8'h3E, 8'h64, 8'h65}) begin
          s.p = s.p + 6'd1;
        end else if (c == OpcVex3 && s.p + 6'd3 <= 6'(WinBytes)) begin
          s.p = s.p + 6'd3;
        end else if (c == OpcVex2 && s.p + 6'd2 <= 6'(WinBytes)) begin
          s.p = s.p + 6'd2;
        end else if (c == OpcEvex && s.p + 6'd4 <= 6'(WinBytes)) begin
          s.p = s.p + 6'd4;
        end else begin
          s.stop = 1'b1;
        end
      end
    end
    return s;
  endfunction

  logic         s1_valid_q, s2_valid_q;
  logic [127:0] s1_win_q, s2_win_q;
  scan_t        s1_scan_q, s1_scan_d;
  scan_t        s2_scan_d;
  logic [4:0]   s2_pl_q;
  logic [7:0]   s2_rex_q;
  logic         s2_f3_q, s2_f3_d;
  logic         s2_move, s2_ready, s1_move, s1_ready, accept;
  scan_t        scan_init;

  assign s2_move  = s2_valid_q && !full_i;
  assign s2_ready = !s2_valid_q || s2_move;
  assign s1_move  = s1_valid_q && s2_ready;
  assign s1_ready = !s1_valid_q || s1_move;
  assign busy     = !s1_ready;
  assign accept   = start && s1_ready;

  assign scan_init = '{p: 6'd0, rex: 8'h00, stop: 1'b0};
  assign s1_scan_d = scan8({req_i.code_high, req_i.code_low}, scan_init);
  assign s2_scan_d = scan8(s1_win_q, s1_scan_q);

  always_comb begin
    s2_f3_d = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (6'(i) < s2_scan_d.p && s1_win_q[i*8 +: 8] == OpcF3) s2_f3_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= start;
      if (s2_ready) s2_valid_q <= s1_move;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_win_q  <= {req_i.code_high, req_i.code_low};
      s1_scan_q <= s1_scan_d;
    end
    if (s1_move) begin
      s2_win_q <= s1_win_q;
      s2_pl_q  <= s2_scan_d.p[4:0];
      s2_rex_q <= s2_scan_d.rex;
      s2_f3_q  <= s2_f3_d;
    end
  end

  assign push_o      = s2_move;
  assign push_data_o = '{win: s2_win_q, pfx_len: s2_pl_q, rex: s2_rex_q, f3_seen: s2_f3_q};

endmodule

FILE: design/ilc_queue.sv
// ----------------------------------------------------------------------------
// ilc_queue
// Small FIFO between the prefix scanner and the opcode decoder.
// ----------------------------------------------------------------------------
module ilc_queue #(
  parameter int unsigned Depth = ilc_pkg::QDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ilc_pkg::ilc_fe_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output ilc_pkg::ilc_fe_t head_o
);
  import ilc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ilc_fe_t         mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

FILE: design/ilc_back.sv
// ----------------------------------------------------------------------------
// ilc_back
// Opcode, ModRM and SIB decode: length, class and relocation fields.
// ----------------------------------------------------------------------------
module ilc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  ilc_pkg::ilc_fe_t  head_i,
  output logic              pop_o,
  output logic              valid_o,
  output ilc_pkg::insn_res_t res_o
);
  import ilc_pkg::*;

  // bit 4 set: opcode has no ModRM; bits 3:0 immediate bytes
  function automatic logic [4:0] plain_imm(logic [7:0] op, logic [7:0] rex);
    logic [4:0] r;
    r = 5'd0;
    case (op) inside
      [8'h50:8'h5F]:                                   r = {1'b1, 4'd0};
      [8'hB0:8'hB7], [8'h70:8'h7F], [8'hE0:8'hE7]:     r = {1'b1, 4'd1};
      [8'hB8:8'hBF]:                                   r = {1'b1, rex[3] ? 4'd8 : 4'd4};
      8'h68, 8'hA9, 8'hE8, 8'hE9:                      r = {1'b1, 4'd4};
      8'h6A, 8'hA8, 8'hCD, 8'hEB:                      r = {1'b1, 4'd1};
      [8'h6C:8'h6F], [8'hA4:8'hA7], [8'hAA:8'hAF],
      8'hC3, 8'hC9, 8'hCB, 8'hCC, 8'hCF, 8'hD7,
      8'hF4, 8'hF5, [8'hF8:8'hFD], [8'h9C:8'h9F]:      r = {1'b1, 4'd0};
      [8'hA0:8'hA3]:                                   r = {1'b1, 4'd8};
      8'hC2, 8'hCA:                                    r = {1'b1, 4'd2};
      8'hC8:                                           r = {1'b1, 4'd3};
      8'h9A:                                           r = {1'b1, 4'd6};
      default:                                         r = 5'd0;
    endcase
    return r;
  endfunction

  localparam logic [5:0] Win = 6'(WinBytes);

  logic [127:0] w;
  logic [5:0]   pl, p1, p2, mpos, pp, len, m4;
  logic [7:0]   op, o2, b2, mb, sib;
  logic [4:0]   pimm;
  logic         early, mo_ok, o2_nomodrm;
  logic [2:0]   disp, imm;
  logic [2:0]   cls;
  logic [5:0]   rs, rel, flen;
  logic [31:0]  rip;

  logic         valid_q;
  insn_res_t    res_q;

  assign pop_o = !empty_i;

  always_comb begin
    w    = head_i.win;
    pl   = {1'b0, head_i.pfx_len};
    p1   = pl + 6'd1;
    p2   = pl + 6'd2;
    op   = byte_at(w, pl);
    o2   = byte_at(w, p1);
    b2   = byte_at(w, p2);
    pimm = plain_imm(op, head_i.rex);
    o2_nomodrm = o2 inside {8'h05, 8'h06, 8'h07, 8'h09, 8'h0B, 8'h30, 8'h31,
                            8'h32, 8'h34, 8'h35, 8'hA2, 8'hAA};
    early = 1'b0;
    len   = 6'd1;
    mpos  = p1;
    mo_ok = op != OpcJmpF;
    if (pl >= Win) begin
      early = 1'b1;
      mo_ok = 1'b0;
    end else if (pimm[4]) begin
      early = 1'b1;
      mo_ok = 1'b0;
      len   = p1 + 6'(pimm[3:0]);
    end else if (op == Opc0F) begin
      if (p1 >= Win) begin
        early = 1'b1;
        mo_ok = 1'b0;
      end else if (o2 == Opc38 || o2 == Opc3A) begin
        if (p2 >= Win) begin
          early = 1'b1;
          mo_ok = 1'b0;
        end else begin
          mpos = p2 + 6'd1;
        end
      end else if (o2_nomodrm) begin
        early = 1'b1;
        mo_ok = 1'b0;
        len   = p2;
      end else if (o2 inside {[8'h80:8'h8F]}) begin
        early = 1'b1;
        mo_ok = 1'b0;
        len   = p2 + 6'd4;
      end else begin
        mpos = p2;
      end
    end
    if (mpos >= Win) mo_ok = 1'b0;

    mb   = byte_at(w, mpos);
    sib  = byte_at(w, mpos + 6'd1);
    disp = 3'd0;
    if (mb[7:6] == 2'd1)                      disp = 3'd1;
    else if (mb[7:6] == 2'd2)                 disp = 3'd4;
    else if (mb[7:6] == 2'd0 && mb[2:0] == 3'd5) disp = 3'd4;
    imm = 3'd0;
    case (op) inside
      8'h80, 8'h82, 8'h83, 8'hC0, 8'hC1: imm = 3'd1;
      8'h81:                             imm = 3'd4;
      8'hC6, 8'hF6:                      imm = (mb[5:3] == 3'd0) ? 3'd1 : 3'd0;
      8'hC7, 8'hF7:                      imm = (mb[5:3] == 3'd0) ? 3'd4 : 3'd0;
      default:                           imm = 3'd0;
    endcase
    pp = mpos + 6'd1;
    if (!early) begin
      if (mpos >= Win) begin
        len = mpos;
      end else if (mb[7:6] != 2'd3 && mb[2:0] == 3'd4) begin
        if (pp >= Win) begin
          len = pp + 6'(disp);
        end else begin
          if (mb[7:6] == 2'd0 && sib[2:0] == 3'd5) disp = 3'd4;
          len = pp + 6'd1 + 6'(disp) + 6'(imm);
        end
      end else begin
        len = pp + 6'(disp) + 6'(imm);
      end
    end

    // classification
    cls  = ClsOther;
    flen = len;
    rs   = len;
    rel  = 6'd0;
    rip  = 32'd0;
    m4   = mpos + 6'd4;
    if (head_i.f3_seen && pl + 6'd3 <= Win && op == Opc0F && o2 == Opc1E && b2 == OpcFA) begin
      cls  = ClsCet;
      flen = pl + 6'd3;
      rs   = pl + 6'd3;
    end else if (pl < Win) begin
      if (op == OpcCall) begin
        cls = ClsCall; flen = pl + 6'd5; rs = 6'd5; rel = p1;
      end else if (op == OpcJmp) begin
        cls = ClsJmp; flen = pl + 6'd5; rs = 6'd5; rel = p1;
      end else if (op == OpcJmpS) begin
        cls = ClsJmp; flen = p2; rs = 6'd5; rel = p1;
      end else if (op == Opc0F && p1 < Win && o2 inside {[8'h80:8'h8F]}) begin
        cls = ClsJcc; flen = pl + 6'd6; rs = 6'd6; rel = p2;
      end else if (op inside {[8'h70:8'h7F]}) begin
        cls = ClsJcc; flen = p2; rs = 6'd6; rel = p1;
      end else if (op == OpcRet) begin
        cls = ClsRet; flen = p1; rs = 6'd1;
      end else if (op == OpcRetI) begin
        cls = ClsRet; flen = pl + 6'd3; rs = 6'd3;
      end else if (mo_ok && (mb & 8'hC7) == 8'h05) begin
        cls = ClsRip;
        rs  = 6'd0;
        if (m4 < len && m4 < Win) begin
          rip = {byte_at(w, m4), byte_at(w, mpos + 6'd3),
                 byte_at(w, mpos + 6'd2), byte_at(w, mpos + 6'd1)};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!empty_i) begin
      res_q.insn_length      <= flen[4:0];
      res_q.insn_class       <= cls;
      res_q.rewrite_size     <= rs[4:0];
      res_q.rel_field_offset <= rel[4:0];
      res_q.rip_displacement <= signed'(rip);
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: design/x86_64_insn_length_classifier.sv
// ----------------------------------------------------------------------------
// x86_64_insn_length_classifier
// Length decode and branch/RIP classification of one x86-64 instruction.
// ----------------------------------------------------------------------------
// Usage: drive a 16-byte code window on req_i and raise start; the request
// is taken on a clock edge where start is high and busy is low. The result
// is on res_o for exactly one cycle with valid_o high, after the request has
// passed the front stages, the queue and the back-end result register. One
// request per cycle is sustained while busy stays low.
// Front: two register stages, each resolving up to eight prefix bytes (legacy,
// REX, VEX, EVEX); the second also flags an F3 prefix. A small FIFO
// (QueueDepth entries) decouples it from the back end, which decodes
// opcode/ModRM/SIB and registers the result.
// The receiver cannot stall: the back end drains one entry per cycle, so busy
// stays low in normal operation and only rises if the queue fills.
// Reset (rst_ni low, asynchronous) drops every request in flight and clears
// the valid bits and queue pointers; no result is produced for them.
// ----------------------------------------------------------------------------
module x86_64_insn_length_classifier #(
  parameter int unsigned QueueDepth = ilc_pkg::QDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ilc_pkg::insn_req_t req_i,
  output logic               valid_o,
  output ilc_pkg::insn_res_t res_o
);
  import ilc_pkg::*;

  logic    push, full, pop, empty;
  ilc_fe_t push_data, head;

  ilc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  ilc_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  ilc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

endmodule

FILE: design/ilc_checker.sv
// ----------------------------------------------------------------------------
// ilc_props
// Port-level checks on request/result timing and result consistency.
// ----------------------------------------------------------------------------
module ilc_props (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               valid_o,
  input ilc_pkg::insn_res_t res_o
);
  import ilc_pkg::*;

  // every accepted request is answered on valid_o, with a never-stalling receiver
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 valid_o)
    else $error("request not answered after four cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, 4))
    else $error("result without matching request");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> res_o.insn_length != 5'd0)
    else $error("zero instruction length");

  a_rip_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.insn_class == ClsRip) |->
      (res_o.rewrite_size == 5'd0 && res_o.rel_field_offset == 5'd0))
    else $error("RIP-relative result with relocation fields set");

  a_other_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.insn_class == ClsOther) |->
      (res_o.rel_field_offset == 5'd0 && res_o.rip_displacement == 32'sd0 &&
       res_o.rewrite_size == res_o.insn_length))
    else $error("plain instruction with branch or RIP fields");

endmodule

bind x86_64_insn_length_classifier ilc_props u_ilc_props (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .valid_o (valid_o),
  .res_o   (res_o)
);

FILE: sim/ilc_checker.sv
// ----------------------------------------------------------------------------
// ilc_checker
// Watches the request and result channels of the length classifier, predicts
// each result from the code window taken and compares it field by field.
// ----------------------------------------------------------------------------
module ilc_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  ilc_pkg::insn_req_t req_i,
  input  logic               valid_i,
  input  ilc_pkg::insn_res_t res_i,
  output int                 pending_o,
  output int                 errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ilc_pkg::*;

  insn_res_t decode_q[$];

  function automatic logic [7:0] bt(logic [127:0] w, int i);
    if (i < 0 || i >= 16) return 8'h00;
    return w[i*8 +: 8];
  endfunction

  function automatic bit is_legacy(logic [7:0] c);
    return c == 8'h66 || c == 8'h67 || c == 8'hF0 || c == 8'hF2 || c == OpcF3 ||
           c == 8'h26 || c == 8'h2E || c == 8'h36 || c == 8'h3E ||
           c == 8'h64 || c == 8'h65;
  endfunction

  function automatic int pfx_scan(logic [127:0] w, output logic [7:0] rex);
    int p;
    logic [7:0] c;
    p = 0;
    rex = 8'h00;
    while (p < 16) begin
      c = bt(w, p);
      if (c >= 8'h40 && c <= 8'h4F) begin
        rex = c;
        p++;
      end else if (is_legacy(c)) p++;
      else if (c == OpcVex3 && p + 3 <= 16) p += 3;
      else if (c == OpcVex2 && p + 2 <= 16) p += 2;
      else if (c == OpcEvex && p + 4 <= 16) p += 4;
      else break;
    end
    return p;
  endfunction

  function automatic bit no_modrm_0f(logic [7:0] o);
    case (o)
      8'h05, 8'h06, 8'h07, 8'h09, 8'h0B, 8'h30, 8'h31, 8'h32, 8'h34, 8'h35,
      8'hA2, 8'hAA: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // immediate bytes of a one-byte opcode without ModRM, -1 when it has one
  function automatic int plain_imm(logic [7:0] op, logic [7:0] rex);
    if (op >= 8'h50 && op <= 8'h5F) return 0;
    if (op >= 8'hB0 && op <= 8'hB7) return 1;
    if (op >= 8'hB8 && op <= 8'hBF) return rex[3] ? 8 : 4;
    if (op >= 8'h70 && op <= 8'h7F) return 1;
    if (op >= 8'hE0 && op <= 8'hE7) return 1;
    case (op)
      8'h68, 8'hA9, OpcCall, OpcJmp: return 4;
      8'h6A, 8'hA8, 8'hCD, OpcJmpS: return 1;
      8'hA0, 8'hA1, 8'hA2, 8'hA3: return 8;
      OpcRetI, 8'hCA: return 2;
      8'hC8: return 3;
      8'h9A: return 6;
      8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'hA4, 8'hA5, 8'hA6, 8'hA7, 8'hAA, 8'hAB,
      8'hAC, 8'hAD, 8'hAE, 8'hAF, OpcRet, 8'hC9, 8'hCB, 8'hCC, 8'hCF, 8'hD7,
      8'hF4, 8'hF5, 8'hF8, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD,
      8'h9C, 8'h9D, 8'h9E, 8'h9F: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic int insn_len(logic [127:0] w);
    int p, k, disp, imm;
    logic [7:0] rex, op, o2, m, sb;
    logic [1:0] md;
    logic [2:0] rm, rg;
    disp = 0;
    imm = 0;
    p = pfx_scan(w, rex);
    if (p >= 16) return 1;
    op = bt(w, p);
    p++;
    k = plain_imm(op, rex);
    if (k >= 0) return p + k;
    if (op == Opc0F) begin
      if (p >= 16) return 1;
      o2 = bt(w, p);
      p++;
      if (o2 == Opc38 || o2 == Opc3A) begin
        if (p >= 16) return 1;
        p++;
      end else if (no_modrm_0f(o2)) return p;
      else if (o2 >= 8'h80 && o2 <= 8'h8F) return p + 4;
    end
    if (p >= 16) return p;
    m = bt(w, p);
    p++;
    md = m[7:6];
    rm = m[2:0];
    rg = m[5:3];
    if (md == 2'd1) disp = 1;
    else if (md == 2'd2) disp = 4;
    else if (md == 2'd0 && rm == 3'd5) disp = 4;
    if (md != 2'd3 && rm == 3'd4) begin
      if (p >= 16) return p + disp;
      sb = bt(w, p);
      if (md == 2'd0 && sb[2:0] == 3'd5) disp = 4;
      p++;
    end
    case (op)
      8'h80, 8'h82, 8'h83, 8'hC0, 8'hC1: imm = 1;
      8'h81: imm = 4;
      8'hC6, 8'hF6: if (rg == 3'd0) imm = 1;
      8'hC7, 8'hF7: if (rg == 3'd0) imm = 4;
      default: ;
    endcase
    return p + disp + imm;
  endfunction

  function automatic int modrm_pos(logic [127:0] w);
    int p;
    logic [7:0] rex, op, o2;
    p = pfx_scan(w, rex);
    if (p >= 16) return -1;
    op = bt(w, p);
    p++;
    if (op == Opc0F) begin
      if (p >= 16) return -1;
      o2 = bt(w, p);
      p++;
      if (o2 == Opc38 || o2 == Opc3A) begin
        if (p >= 16) return -1;
        return p + 1;
      end
      if (no_modrm_0f(o2) || (o2 >= 8'h80 && o2 <= 8'h8F)) return -1;
      return p;
    end
    if (op == OpcJmpF) return -1;
    if (plain_imm(op, rex) >= 0) return -1;
    return p;
  endfunction

  function automatic insn_res_t classify(insn_req_t r);
    logic [127:0] w;
    logic [7:0] rex, op;
    int pl, p, len, rs, rel, mo;
    insn_class_e cls;
    logic [31:0] rip;
    bit done, f3;
    insn_res_t o;
    w = {r.code_high, r.code_low};
    pl = pfx_scan(w, rex);
    p = pl;
    len = 0;
    rs = 0;
    rel = 0;
    rip = '0;
    cls = ClsOther;
    done = 0;
    f3 = 0;
    for (int i = 0; i < pl; i++) if (bt(w, i) == OpcF3) f3 = 1;
    if (f3 && p + 3 <= 16 && bt(w, p) == Opc0F && bt(w, p + 1) == Opc1E &&
        bt(w, p + 2) == OpcFA) begin
      cls = ClsCet; len = pl + 3; rs = len; done = 1;
    end
    if (!done && p < 16) begin
      op = bt(w, p);
      p++;
      if (op == OpcCall) begin
        cls = ClsCall; len = pl + 5; rs = 5; rel = pl + 1; done = 1;
      end else if (op == OpcJmp) begin
        cls = ClsJmp; len = pl + 5; rs = 5; rel = pl + 1; done = 1;
      end else if (op == OpcJmpS) begin
        cls = ClsJmp; len = pl + 2; rs = 5; rel = pl + 1; done = 1;
      end else if (op == Opc0F && p < 16 && bt(w, p) >= 8'h80 && bt(w, p) <= 8'h8F) begin
        cls = ClsJcc; len = pl + 6; rs = 6; rel = pl + 2; done = 1;
      end else if (op >= 8'h70 && op <= 8'h7F) begin
        cls = ClsJcc; len = pl + 2; rs = 6; rel = pl + 1; done = 1;
      end else if (op == OpcRet) begin
        cls = ClsRet; len = pl + 1; rs = 1; done = 1;
      end else if (op == OpcRetI) begin
        cls = ClsRet; len = pl + 3; rs = 3; done = 1;
      end else if (!(op == Opc0F && p >= 16)) begin
        mo = modrm_pos(w);
        if (mo >= 0 && mo < 16 && (bt(w, mo) & 8'hC7) == 8'h05) begin
          cls = ClsRip; len = insn_len(w); rs = 0; done = 1;
          // disp32 only when it lies wholly inside the window
          if (mo + 4 < len && mo + 4 < 16)
            rip = {bt(w, mo + 4), bt(w, mo + 3), bt(w, mo + 2), bt(w, mo + 1)};
        end
      end
    end
    if (!done) begin
      cls = ClsOther; len = insn_len(w); rs = len; rel = 0; rip = '0;
    end
    o.insn_length      = 5'(len);
    o.insn_class       = cls;
    o.rewrite_size     = 5'(rs);
    o.rel_field_offset = 5'(rel);
    o.rip_displacement = rip;
    return o;
  endfunction

  initial errors_o = 0;
  assign pending_o = decode_q.size();

  always @(posedge clk_i) begin
    insn_res_t e;
    if (rst_ni) begin
      if (start_i && !busy_i) decode_q.push_back(classify(req_i));
      if (valid_i) begin
        if (decode_q.size() == 0) begin
          $display("%0t: result with none outstanding: %h", $time, res_i);
          errors_o <= errors_o + 1;
        end else begin
          e = decode_q.pop_front();
          if (e !== res_i) begin
            $display("%0t: mismatch len %0d/%0d cls %0d/%0d rs %0d/%0d rel %0d/%0d rip %h/%h",
                     $time, e.insn_length, res_i.insn_length, e.insn_class,
                     res_i.insn_class, e.rewrite_size, res_i.rewrite_size,
                     e.rel_field_offset, res_i.rel_field_offset,
                     e.rip_displacement, res_i.rip_displacement);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random code windows into the length classifier with
// random sender gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ilc_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  insn_req_t req = '0;
  logic      valid_o;
  insn_res_t res_o;
  int        pending, errors;
  logic [7:0] wb[16];
  int        idle_pct;

  always #5 clk_i = ~clk_i;

  x86_64_insn_length_classifier i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req), .valid_o(valid_o), .res_o(res_o)
  );

  ilc_checker i_chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy),
    .req_i(req), .valid_i(valid_o), .res_i(res_o),
    .pending_o(pending), .errors_o(errors)
  );

  // n bytes from seq, first byte most significant, placed from pos upward
  task automatic put(int pos, logic [63:0] seq, int n);
    for (int i = 0; i < n; i++) if (pos + i < 16) wb[pos + i] = seq[8*(n-1-i) +: 8];
  endtask

  task automatic fill(logic [7:0] v);
    for (int i = 0; i < 16; i++) wb[i] = v;
  endtask

  task automatic fill_rand();
    for (int i = 0; i < 16; i++) wb[i] = 8'($urandom);
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request();
    int gap;
    insn_req_t nxt;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    for (int i = 0; i < 8; i++) begin
      nxt.code_low[i*8 +: 8]  = wb[i];
      nxt.code_high[i*8 +: 8] = wb[i+8];
    end
    req   <= nxt;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic make_random();
    logic [7:0] pfx[14];
    int np, p;
    fill_rand();
    if ($urandom_range(99) < 20) return;
    pfx = '{8'h66, 8'h67, 8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h64, 8'h48, 8'h41,
            8'h4C, OpcVex3, OpcVex2, OpcEvex, 8'h3E};
    np = ($urandom_range(99) < 10) ? $urandom_range(8, 16) : $urandom_range(0, 3);
    p = 0;
    for (int i = 0; i < np && p < 16; i++) begin
      wb[p] = pfx[$urandom_range(13)];
      if (wb[p] == OpcVex3) p += 3;
      else if (wb[p] == OpcVex2) p += 2;
      else if (wb[p] == OpcEvex) p += 4;
      else p++;
    end
    if (p >= 16) return;
    case ($urandom_range(15))
      0: wb[p] = OpcCall;
      1: wb[p] = ($urandom_range(1)) ? OpcJmp : OpcJmpS;
      2: wb[p] = 8'h70 + 8'($urandom_range(15));
      3: wb[p] = ($urandom_range(1)) ? OpcRet : OpcRetI;
      4: put(p, 16'h0F80 + 16'($urandom_range(15)), 2);
      5: put(p, 24'h0F1EFA, 3);
      6: put(p, ($urandom_range(1)) ? 16'h0F38 : 16'h0F3A, 2);
      7: put(p, 16'h0F00 + 16'($urandom_range(255)), 2);
      8: wb[p] = 8'hB8 + 8'($urandom_range(7));
      9: wb[p] = ($urandom_range(1)) ? 8'h81 : 8'h80;
      10: wb[p] = ($urandom_range(1)) ? 8'hC7 : 8'hF7;
      default: wb[p] = ($urandom_range(1)) ? 8'h8B : 8'h89;
    endcase
    // bias the next byte towards RIP-relative or SIB forms
    if (p + 1 < 16 && wb[p] != Opc0F) begin
      case ($urandom_range(3))
        0: wb[p+1] = (wb[p+1] & 8'h38) | 8'h05;
        1: wb[p+1] = (wb[p+1] & 8'hF8) | 8'h04;
        default: ;
      endcase
    end
  endtask

  initial begin
    idle_pct = 28;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    fill(8'h00); send_request();
    fill(8'hFF); send_request();
    fill(8'h90); put(0, 8'hC3, 1); send_request();
    fill(8'h90); put(0, 24'hC21000, 3); send_request();
    fill(8'h11); put(0, 8'hE8, 1); send_request();
    fill(8'h22); put(0, 16'h66E9, 2); send_request();
    fill(8'h33); put(0, 8'hEB, 1); send_request();
    fill(8'h44); put(0, 8'h74, 1); send_request();
    fill(8'h55); put(0, 24'h480F85, 3); send_request();
    fill(8'h90); put(0, 32'hF30F1EFA, 4); send_request();
    fill(8'h90); put(0, 40'hF3660F1EFB, 5); send_request();
    fill(8'h00); put(0, 64'h488B0578563412C3, 8); send_request();
    fill(8'h66); put(13, 24'h8B05FF, 3); send_request();
    fill(8'h66); send_request();
    fill(8'h66); put(15, 8'h0F, 1); send_request();
    fill(8'h66); put(14, 16'h0F38, 2); send_request();
    fill(8'h66); put(14, 16'hC490, 2); send_request();
    fill(8'h90); put(0, 56'h62F1FD480F1E05, 7); send_request();
    fill(8'h00); put(0, 16'h48B8, 2); send_request();
    fill(8'h00); put(0, 32'h81042578, 4); send_request();
    fill(8'h00); put(0, 8'h9A, 1); send_request();
    fill(8'h00); put(0, 16'hF740, 2); send_request();
    fill(8'h00); put(0, 32'h8B44E408, 4); send_request();
    fill(8'hAA); put(0, 32'h0F3A0F05, 4); send_request();

    // hold off until the pipeline has drained
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);

    for (int n = 0; n < 850; n++) begin
      idle_pct = (n < 280) ? 28 : (n < 560) ? 69 : 0;
      make_random();
      send_request();
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: x86_64_insn_length_classifier.f
design/ilc_pkg.sv
design/ilc_front.sv
design/ilc_queue.sv
design/ilc_back.sv
design/x86_64_insn_length_classifier.sv
design/ilc_checker.sv
sim/ilc_checker.sv
sim/tb_top.sv
